// ===== src/fpgm_pkg.sv =====
// Shared constants and types for the feature-point global motion core.
// Depends on nothing; every other file refers to it by scoped names.
package fpgm_pkg;

	localparam int MAX_POINTS = 64;
	localparam int PT_IDX_W   = 6;
	localparam int PT_CNT_W   = 7;
	localparam int COORD_W    = 16;
	localparam int OFS_W      = 24;
	localparam int APB_ADDR_W = 5;

	localparam logic [15:0] WEIGHT_ONE = 16'hFFFF;

	typedef enum logic [2:0] {
		REG_MATCH_RADIUS  = 3'd0,
		REG_KEEP_FACTOR   = 3'd1,
		REG_NEW_FACTOR    = 3'd2,
		REG_REFINE_ROUNDS = 3'd3,
		REG_MIN_MATCHES   = 3'd4
	} reg_idx_t;

	localparam logic [11:0] RST_MATCH_RADIUS  = 12'd256;
	localparam logic [14:0] RST_KEEP_FACTOR   = 15'd28836;
	localparam logic [14:0] RST_NEW_FACTOR    = 15'd6226;
	localparam logic [5:0]  RST_REFINE_ROUNDS = 6'd20;
	localparam logic [6:0]  RST_MIN_MATCHES   = 7'd4;

endpackage

// ===== src/fpgm_point_if.sv =====
// Input channel of the motion core: one feature point per beat.
// Depends on fpgm_pkg for field widths.
interface fpgm_point_if;
	logic valid;
	logic ready;
	logic [fpgm_pkg::COORD_W-1:0] point_x;
	logic [fpgm_pkg::COORD_W-1:0] point_y;
	logic point_present;
	logic frame_last;

	modport source (output valid, point_x, point_y, point_present, frame_last, input ready);
	modport sink (input valid, point_x, point_y, point_present, frame_last, output ready);
endinterface

// ===== src/fpgm_motion_if.sv =====
// Result channel of the motion core: one motion estimate per frame.
// Depends on fpgm_pkg for field widths.
interface fpgm_motion_if;
	logic valid;
	logic ready;
	logic signed [fpgm_pkg::OFS_W-1:0] horiz_offset;
	logic signed [fpgm_pkg::OFS_W-1:0] vert_offset;
	logic estimate_updated;
	logic [fpgm_pkg::PT_CNT_W-1:0] matched_count;

	modport source (output valid, horiz_offset, vert_offset, estimate_updated, matched_count,
		input ready);
	modport sink (input valid, horiz_offset, vert_offset, estimate_updated, matched_count,
		output ready);
endinterface

// ===== src/feature_point_global_motion_core.sv =====
// Top level of the feature-point global motion core.
// Depends on fpgm_pkg, fpgm_point_if and fpgm_motion_if.

// A frame's feature points arrive one beat each on the points channel, and the beat with
// frame_last set closes the frame. Beats without frame_last leave the core idle and ready
// for the next beat. On the closing beat the core pairs every stored point of the previous
// frame (or, when no points are stored, every new point) with its nearest new point. If
// the M matches reach min_matches (at least one), it forms max(1, refine_rounds)
// iteratively reweighted means of the matched shifts, with a weight update between each
// two of them, and updates two smoothed offsets; in either case it then sends one beat on
// the motion channel. All of that runs through one shared sequencer with a single 25x23
// multiplier, a one-bit-per-cycle divider and a two-bit-per-cycle square root. The result
// loads into the output register once the previous result has been taken. The points
// channel is not ready for that whole time. The result sits in an output register, so
// the core accepts the next frame's points while it waits to be taken. Configuration
// registers are to be written over the APB port only while the core is idle; the core
// itself does not enforce this.
module feature_point_global_motion_core (
	input  logic clk,
	input  logic arst_n,
	fpgm_point_if.sink points,
	fpgm_motion_if.source motion,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [fpgm_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	typedef enum logic [5:0] {
		S_IDLE, S_SETUP, S_R2, S_REF_RD, S_REF_WAIT, S_CUR_RD, S_CUR_DIF, S_SQX, S_SQY, S_CMP,
		S_PAIR_END, S_MATCH_DONE, S_MEAN_INIT, S_ACC_RD, S_ACC_WX, S_ACC_WY, S_ACC_ADD,
		S_DIVX, S_GOTX, S_GOTY, S_DIV, S_UPD_RD, S_UPD_DIF, S_UPD_SQX, S_UPD_SQY, S_UPD_SUM,
		S_SQRT, S_UPD_DIV, S_UPD_WR, S_SCL_INIT, S_SCL_RD, S_SCL_DIV, S_SCL_WR,
		S_SMX, S_SMX2, S_SMX3, S_SMY, S_SMY2, S_SMY3, S_EMIT
	} state_t;

	// Configuration registers.
	logic [11:0] radius_q;
	logic [14:0] keep_q;
	logic [14:0] new_q;
	logic [5:0]  rounds_q;
	logic [6:0]  minm_q;

	// Frame bookkeeping. The point memory holds two banks; loading the result swaps them.
	logic cur_bank_q;
	logic ref_bank_q;
	logic [6:0] cur_total_q;
	logic [6:0] prev_total_q;
	logic [6:0] ref_n_q;

	state_t state_q;
	state_t div_ret_q;

	// Matching.
	logic [6:0] i_q;
	logic [6:0] j_q;
	logic [6:0] m_q;
	logic [15:0] ref_x_q;
	logic [15:0] ref_y_q;
	logic signed [16:0] dx_q;
	logic signed [16:0] dy_q;
	logic signed [16:0] bdx_q;
	logic signed [16:0] bdy_q;
	logic [33:0] sq_m_q;
	logic [33:0] best_q;
	logic found_q;
	logic [23:0] r2_q;

	// Robust mean.
	logic [6:0] k_q;
	logic [5:0] rd_q;
	logic first_q;
	logic signed [43:0] sx_q;
	logic signed [43:0] sy_q;
	logic [21:0] sw_q;
	logic signed [21:0] mx_q;
	logic signed [21:0] my_q;
	logic signed [21:0] ex_q;
	logic signed [21:0] ey_q;
	logic [43:0] sq_u_q;
	logic [15:0] w_cur_q;
	logic [31:0] wmax_q;

	// Square root.
	logic [43:0] rt_v_q;
	logic [43:0] rt_r_q;
	logic [43:0] rt_b_q;

	// Divider: the quotient shifts in where the numerator shifts out.
	logic [47:0] div_num_q;
	logic [31:0] div_den_q;
	logic [31:0] div_rem_q;
	logic [5:0]  div_cnt_q;

	// Shared multiplier.
	logic signed [24:0] mul_a;
	logic signed [22:0] mul_b;
	logic signed [47:0] mul_q;

	// Smoothing.
	logic signed [40:0] acc_q;
	logic signed [23:0] hsm_q;
	logic signed [23:0] vsm_q;
	logic upd_q;

	// Output register.
	logic out_valid_q;
	logic signed [23:0] out_h_q;
	logic signed [23:0] out_v_q;
	logic out_upd_q;
	logic [6:0] out_cnt_q;

	// Memories.
	logic [31:0] pt_mem [0:2*fpgm_pkg::MAX_POINTS-1];
	logic [33:0] sh_mem [0:fpgm_pkg::MAX_POINTS-1];
	logic [15:0] w_mem  [0:fpgm_pkg::MAX_POINTS-1];
	logic [31:0] nw_mem [0:fpgm_pkg::MAX_POINTS-1];
	logic [31:0] pt_rd_q;
	logic [33:0] sh_rd_q;
	logic [15:0] w_rd_q;
	logic [31:0] nw_rd_q;

	logic in_acc;
	logic pt_we;
	logic [6:0] pt_raddr;
	logic signed [16:0] sdx_rd;
	logic signed [16:0] sdy_rd;
	logic [15:0] wsel;
	logic [33:0] d2;
	logic [43:0] sq_sum;
	logic [43:0] rt_rb;
	logic [32:0] div_rem_sh;
	logic div_take;
	logic [6:0] need;
	logic [43:0] sx_mag;
	logic [43:0] sy_mag;
	logic cfg_wr;

	function automatic logic signed [23:0] round_sat(input logic signed [40:0] acc);
		logic [40:0] mag;
		logic [25:0] q;
		logic signed [26:0] sv;
		mag = acc[40] ? 41'(-acc) : 41'(acc);
		q = 26'((mag + 41'd16384) >> 15);
		sv = acc[40] ? -$signed({1'b0, q}) : $signed({1'b0, q});
		if (sv > 27'sd8388607) begin
			return 24'sh7FFFFF;
		end else if (sv < -27'sd8388608) begin
			return -24'sh800000;
		end
		return 24'(sv);
	endfunction

	assign points.ready = (state_q == S_IDLE);
	assign in_acc = points.valid && points.ready;
	assign pt_we = in_acc && points.point_present && (cur_total_q < 7'(fpgm_pkg::MAX_POINTS));
	assign pt_raddr = (state_q == S_REF_RD) ? {ref_bank_q, i_q[5:0]} : {cur_bank_q, j_q[5:0]};

	assign sdx_rd = $signed(sh_rd_q[33:17]);
	assign sdy_rd = $signed(sh_rd_q[16:0]);
	assign wsel = first_q ? fpgm_pkg::WEIGHT_ONE : w_rd_q;
	assign d2 = sq_m_q + mul_q[33:0];
	assign sq_sum = sq_u_q + mul_q[43:0];
	assign rt_rb = rt_r_q + rt_b_q;
	assign div_rem_sh = {div_rem_q, div_num_q[47]};
	assign div_take = div_rem_sh >= {1'b0, div_den_q};
	assign need = (minm_q == 7'd0) ? 7'd1 : minm_q;
	assign sx_mag = sx_q[43] ? 44'(-sx_q) : 44'(sx_q);
	assign sy_mag = sy_q[43] ? 44'(-sy_q) : 44'(sy_q);

	assign motion.valid = out_valid_q;
	assign motion.horiz_offset = out_h_q;
	assign motion.vert_offset = out_v_q;
	assign motion.estimate_updated = out_upd_q;
	assign motion.matched_count = out_cnt_q;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		case (paddr[4:2])
			fpgm_pkg::REG_MATCH_RADIUS:  prdata = 32'(radius_q);
			fpgm_pkg::REG_KEEP_FACTOR:   prdata = 32'(keep_q);
			fpgm_pkg::REG_NEW_FACTOR:    prdata = 32'(new_q);
			fpgm_pkg::REG_REFINE_ROUNDS: prdata = 32'(rounds_q);
			fpgm_pkg::REG_MIN_MATCHES:   prdata = 32'(minm_q);
			default:                     prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= fpgm_pkg::RST_MATCH_RADIUS;
			keep_q   <= fpgm_pkg::RST_KEEP_FACTOR;
			new_q    <= fpgm_pkg::RST_NEW_FACTOR;
			rounds_q <= fpgm_pkg::RST_REFINE_ROUNDS;
			minm_q   <= fpgm_pkg::RST_MIN_MATCHES;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				fpgm_pkg::REG_MATCH_RADIUS:  radius_q <= pwdata[11:0];
				fpgm_pkg::REG_KEEP_FACTOR:   keep_q <= pwdata[14:0];
				fpgm_pkg::REG_NEW_FACTOR:    new_q <= pwdata[14:0];
				fpgm_pkg::REG_REFINE_ROUNDS: rounds_q <= pwdata[5:0];
				fpgm_pkg::REG_MIN_MATCHES:   minm_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// Operand selection for the shared multiplier; its product is registered.
	always_comb begin
		mul_a = 25'sd0;
		mul_b = 23'sd0;
		case (state_q)
			S_SETUP: begin
				mul_a = $signed({13'd0, radius_q});
				mul_b = $signed({11'd0, radius_q});
			end
			S_SQX: begin
				mul_a = 25'(dx_q);
				mul_b = 23'(dx_q);
			end
			S_SQY: begin
				mul_a = 25'(dy_q);
				mul_b = 23'(dy_q);
			end
			S_ACC_WX: begin
				mul_a = 25'(sdx_rd);
				mul_b = $signed({7'd0, wsel});
			end
			S_ACC_WY: begin
				mul_a = 25'(sdy_rd);
				mul_b = $signed({7'd0, wsel});
			end
			S_UPD_SQX: begin
				mul_a = 25'(ex_q);
				mul_b = 23'(ex_q);
			end
			S_UPD_SQY: begin
				mul_a = 25'(ey_q);
				mul_b = 23'(ey_q);
			end
			S_SMX: begin
				mul_a = 25'(hsm_q);
				mul_b = $signed({8'd0, keep_q});
			end
			S_SMX2: begin
				mul_a = 25'(mx_q);
				mul_b = $signed({8'd0, new_q});
			end
			S_SMY: begin
				mul_a = 25'(vsm_q);
				mul_b = $signed({8'd0, keep_q});
			end
			S_SMY2: begin
				mul_a = 25'(my_q);
				mul_b = $signed({8'd0, new_q});
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	// Memories: one write and one registered read each per cycle.
	always_ff @(posedge clk) begin
		if (pt_we) begin
			pt_mem[{cur_bank_q, cur_total_q[5:0]}] <= {points.point_y, points.point_x};
		end
		pt_rd_q <= pt_mem[pt_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PAIR_END && found_q && best_q < 34'(r2_q)) begin
			sh_mem[m_q[5:0]] <= {bdx_q, bdy_q};
		end
		sh_rd_q <= sh_mem[k_q[5:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SCL_WR) begin
			w_mem[k_q[5:0]] <= div_num_q[15:0];
		end
		w_rd_q <= w_mem[k_q[5:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_UPD_WR) begin
			nw_mem[k_q[5:0]] <= div_num_q[31:0];
		end
		nw_rd_q <= nw_mem[k_q[5:0]];
	end

	// Sequencer and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			div_ret_q <= S_IDLE;
			cur_bank_q <= 1'b0;
			ref_bank_q <= 1'b0;
			cur_total_q <= 7'd0;
			prev_total_q <= 7'd0;
			ref_n_q <= 7'd0;
			i_q <= 7'd0;
			j_q <= 7'd0;
			m_q <= 7'd0;
			k_q <= 7'd0;
			rd_q <= 6'd0;
			first_q <= 1'b0;
			found_q <= 1'b0;
			div_cnt_q <= 6'd0;
			hsm_q <= 24'sd0;
			vsm_q <= 24'sd0;
			upd_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_h_q <= 24'sd0;
			out_v_q <= 24'sd0;
			out_upd_q <= 1'b0;
			out_cnt_q <= 7'd0;
			ref_x_q <= 16'd0;
			ref_y_q <= 16'd0;
			dx_q <= 17'sd0;
			dy_q <= 17'sd0;
			bdx_q <= 17'sd0;
			bdy_q <= 17'sd0;
			sq_m_q <= 34'd0;
			best_q <= 34'd0;
			r2_q <= 24'd0;
			sx_q <= 44'sd0;
			sy_q <= 44'sd0;
			sw_q <= 22'd0;
			mx_q <= 22'sd0;
			my_q <= 22'sd0;
			ex_q <= 22'sd0;
			ey_q <= 22'sd0;
			sq_u_q <= 44'd0;
			w_cur_q <= 16'd0;
			wmax_q <= 32'd0;
			rt_v_q <= 44'd0;
			rt_r_q <= 44'd0;
			rt_b_q <= 44'd0;
			div_num_q <= 48'd0;
			div_den_q <= 32'd0;
			div_rem_q <= 32'd0;
			acc_q <= 41'sd0;
		end else begin
			// A taken result frees the output register unless a new one loads this cycle.
			if (motion.valid && motion.ready && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (pt_we) begin
							cur_total_q <= cur_total_q + 7'd1;
						end
						if (points.frame_last) begin
							state_q <= S_SETUP;
						end
					end
				end
				S_SETUP: begin
					// With no stored frame the new points are matched against themselves.
					if (prev_total_q == 7'd0) begin
						ref_bank_q <= cur_bank_q;
						ref_n_q <= cur_total_q;
					end else begin
						ref_bank_q <= ~cur_bank_q;
						ref_n_q <= prev_total_q;
					end
					i_q <= 7'd0;
					m_q <= 7'd0;
					state_q <= S_R2;
				end
				S_R2: begin
					r2_q <= mul_q[23:0];
					state_q <= S_REF_RD;
				end
				S_REF_RD: begin
					state_q <= (i_q == ref_n_q) ? S_MATCH_DONE : S_REF_WAIT;
				end
				S_REF_WAIT: begin
					ref_x_q <= pt_rd_q[15:0];
					ref_y_q <= pt_rd_q[31:16];
					j_q <= 7'd0;
					found_q <= 1'b0;
					state_q <= S_CUR_RD;
				end
				S_CUR_RD: begin
					state_q <= (j_q == cur_total_q) ? S_PAIR_END : S_CUR_DIF;
				end
				S_CUR_DIF: begin
					dx_q <= $signed({1'b0, pt_rd_q[15:0]}) - $signed({1'b0, ref_x_q});
					dy_q <= $signed({1'b0, pt_rd_q[31:16]}) - $signed({1'b0, ref_y_q});
					state_q <= S_SQX;
				end
				S_SQX: begin
					state_q <= S_SQY;
				end
				S_SQY: begin
					sq_m_q <= mul_q[33:0];
					state_q <= S_CMP;
				end
				S_CMP: begin
					// Strict compare keeps the earliest point on a tie.
					if (!found_q || d2 < best_q) begin
						found_q <= 1'b1;
						best_q <= d2;
						bdx_q <= dx_q;
						bdy_q <= dy_q;
					end
					j_q <= j_q + 7'd1;
					state_q <= S_CUR_RD;
				end
				S_PAIR_END: begin
					if (found_q && best_q < 34'(r2_q)) begin
						m_q <= m_q + 7'd1;
					end
					i_q <= i_q + 7'd1;
					state_q <= S_REF_RD;
				end
				S_MATCH_DONE: begin
					if (m_q >= need) begin
						first_q <= 1'b1;
						rd_q <= 6'd0;
						state_q <= S_MEAN_INIT;
					end else begin
						upd_q <= 1'b0;
						state_q <= S_EMIT;
					end
				end
				S_MEAN_INIT: begin
					k_q <= 7'd0;
					sx_q <= 44'sd0;
					sy_q <= 44'sd0;
					sw_q <= 22'd0;
					state_q <= S_ACC_RD;
				end
				S_ACC_RD: begin
					state_q <= (k_q == m_q) ? S_DIVX : S_ACC_WX;
				end
				S_ACC_WX: begin
					sw_q <= sw_q + 22'(wsel);
					state_q <= S_ACC_WY;
				end
				S_ACC_WY: begin
					sx_q <= sx_q + 44'(mul_q <<< 4);
					state_q <= S_ACC_ADD;
				end
				S_ACC_ADD: begin
					sy_q <= sy_q + 44'(mul_q <<< 4);
					k_q <= k_q + 7'd1;
					state_q <= S_ACC_RD;
				end
				S_DIVX: begin
					div_num_q <= 48'(sx_mag) + 48'(sw_q >> 1);
					div_den_q <= (sw_q == 22'd0) ? 32'd1 : 32'(sw_q);
					div_rem_q <= 32'd0;
					div_cnt_q <= 6'd0;
					div_ret_q <= S_GOTX;
					state_q <= S_DIV;
				end
				S_GOTX: begin
					mx_q <= sx_q[43] ? -22'(div_num_q) : 22'(div_num_q);
					div_num_q <= 48'(sy_mag) + 48'(sw_q >> 1);
					div_rem_q <= 32'd0;
					div_cnt_q <= 6'd0;
					div_ret_q <= S_GOTY;
					state_q <= S_DIV;
				end
				S_GOTY: begin
					my_q <= sy_q[43] ? -22'(div_num_q) : 22'(div_num_q);
					// The mean of the last round is formed from the weights before its update.
					if (7'(rd_q) + 7'd1 >= 7'(rounds_q)) begin
						upd_q <= 1'b1;
						state_q <= S_SMX;
					end else begin
						k_q <= 7'd0;
						wmax_q <= 32'd0;
						state_q <= S_UPD_RD;
					end
				end
				S_DIV: begin
					div_rem_q <= div_take ? 32'(div_rem_sh - {1'b0, div_den_q}) : div_rem_sh[31:0];
					div_num_q <= {div_num_q[46:0], div_take};
					div_cnt_q <= div_cnt_q + 6'd1;
					if (div_cnt_q == 6'd47) begin
						state_q <= div_ret_q;
					end
				end
				S_UPD_RD: begin
					state_q <= (k_q == m_q) ? S_SCL_INIT : S_UPD_DIF;
				end
				S_UPD_DIF: begin
					ex_q <= mx_q - (22'(sdx_rd) <<< 4);
					ey_q <= my_q - (22'(sdy_rd) <<< 4);
					w_cur_q <= wsel;
					state_q <= S_UPD_SQX;
				end
				S_UPD_SQX: begin
					state_q <= S_UPD_SQY;
				end
				S_UPD_SQY: begin
					sq_u_q <= mul_q[43:0];
					state_q <= S_UPD_SUM;
				end
				S_UPD_SUM: begin
					rt_v_q <= sq_sum;
					rt_r_q <= 44'd0;
					rt_b_q <= 44'd1 << 42;
					state_q <= S_SQRT;
				end
				S_SQRT: begin
					if (rt_b_q == 44'd0) begin
						state_q <= S_UPD_DIV;
					end else begin
						if (rt_v_q >= rt_rb) begin
							rt_v_q <= rt_v_q - rt_rb;
							rt_r_q <= (rt_r_q >> 1) + rt_b_q;
						end else begin
							rt_r_q <= rt_r_q >> 1;
						end
						rt_b_q <= rt_b_q >> 2;
					end
				end
				S_UPD_DIV: begin
					div_num_q <= 48'({w_cur_q, 24'd0});
					div_den_q <= 32'(rt_r_q[21:0]) + 32'd256;
					div_rem_q <= 32'd0;
					div_cnt_q <= 6'd0;
					div_ret_q <= S_UPD_WR;
					state_q <= S_DIV;
				end
				S_UPD_WR: begin
					if (div_num_q[31:0] > wmax_q) begin
						wmax_q <= div_num_q[31:0];
					end
					k_q <= k_q + 7'd1;
					state_q <= S_UPD_RD;
				end
				S_SCL_INIT: begin
					if (wmax_q == 32'd0) begin
						wmax_q <= 32'd1;
					end
					k_q <= 7'd0;
					state_q <= S_SCL_RD;
				end
				S_SCL_RD: begin
					if (k_q == m_q) begin
						first_q <= 1'b0;
						rd_q <= rd_q + 6'd1;
						state_q <= S_MEAN_INIT;
					end else begin
						state_q <= S_SCL_DIV;
					end
				end
				S_SCL_DIV: begin
					// Scale so that the largest weight becomes full scale.
					div_num_q <= 48'({nw_rd_q, 16'd0}) - 48'(nw_rd_q);
					div_den_q <= wmax_q;
					div_rem_q <= 32'd0;
					div_cnt_q <= 6'd0;
					div_ret_q <= S_SCL_WR;
					state_q <= S_DIV;
				end
				S_SCL_WR: begin
					k_q <= k_q + 7'd1;
					state_q <= S_SCL_RD;
				end
				S_SMX: begin
					state_q <= S_SMX2;
				end
				S_SMX2: begin
					acc_q <= mul_q[40:0];
					state_q <= S_SMX3;
				end
				S_SMX3: begin
					hsm_q <= round_sat(acc_q + mul_q[40:0]);
					state_q <= S_SMY;
				end
				S_SMY: begin
					state_q <= S_SMY2;
				end
				S_SMY2: begin
					acc_q <= mul_q[40:0];
					state_q <= S_SMY3;
				end
				S_SMY3: begin
					vsm_q <= round_sat(acc_q + mul_q[40:0]);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (!out_valid_q || motion.ready) begin
						out_valid_q <= 1'b1;
						out_h_q <= hsm_q;
						out_v_q <= vsm_q;
						out_upd_q <= upd_q;
						out_cnt_q <= m_q;
						// The current bank becomes the stored frame.
						cur_bank_q <= ~cur_bank_q;
						prev_total_q <= cur_total_q;
						cur_total_q <= 7'd0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== src/fpgm_checker.sv =====
// Port-level checks for the feature-point global motion core, bound to the top level.
// Depends on fpgm_pkg and on the top level's ports.
module fpgm_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_last,
	input logic out_valid,
	input logic out_ready,
	input logic signed [fpgm_pkg::OFS_W-1:0] out_h,
	input logic signed [fpgm_pkg::OFS_W-1:0] out_v,
	input logic out_upd,
	input logic [fpgm_pkg::PT_CNT_W-1:0] out_cnt
);

	// A result beat that is not taken stays with the same payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_h) && $stable(out_v)
			&& $stable(out_upd) && $stable(out_cnt))
		else $error("result beat changed while stalled");

	// Closing a frame keeps the input side busy in the next cycle.
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("input ready right after a frame_last beat");

	// An update needs at least one match.
	a_upd_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_upd |-> out_cnt != 7'd0)
		else $error("estimate updated without matches");

	// No more matches than stored points.
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_cnt <= 7'(fpgm_pkg::MAX_POINTS))
		else $error("matched count above point limit");

endmodule

bind feature_point_global_motion_core fpgm_checker u_fpgm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(points.valid),
	.in_ready(points.ready),
	.in_last(points.frame_last),
	.out_valid(motion.valid),
	.out_ready(motion.ready),
	.out_h(motion.horiz_offset),
	.out_v(motion.vert_offset),
	.out_upd(motion.estimate_updated),
	.out_cnt(motion.matched_count)
);

// ===== tb/feature_point_global_motion_core_test.sv =====
// Self-checking testbench for feature_point_global_motion_core.
// Depends on fpgm_pkg, fpgm_point_if and fpgm_motion_if; it drives point frames and
// APB writes, and checks each motion beat against its own frame-level predictor.
module feature_point_global_motion_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	// Register slot that the core does not decode; a write there must change nothing.
	localparam logic [2:0] UNMAPPED_REG = 3'd7;
	localparam int SCENE_MAX = 80;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [fpgm_pkg::APB_ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	fpgm_point_if points ();
	fpgm_motion_if motion ();

	feature_point_global_motion_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.points(points.sink),
		.motion(motion.source),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// One expected beat on the motion channel.
	typedef struct {
		logic signed [fpgm_pkg::OFS_W-1:0] horiz;
		logic signed [fpgm_pkg::OFS_W-1:0] vert;
		logic updated;
		logic [fpgm_pkg::PT_CNT_W-1:0] matched;
	} motion_beat_t;

	motion_beat_t pending_motion[$];

	// Predictor copy of the configuration registers.
	int unsigned radius_q, keep_q, gain_q, rounds_q, min_pairs_q;

	// Predictor copy of the point stores and the smoothed offsets.
	logic [fpgm_pkg::COORD_W-1:0] stored_x[fpgm_pkg::MAX_POINTS];
	logic [fpgm_pkg::COORD_W-1:0] stored_y[fpgm_pkg::MAX_POINTS];
	logic [fpgm_pkg::COORD_W-1:0] fresh_x[fpgm_pkg::MAX_POINTS];
	logic [fpgm_pkg::COORD_W-1:0] fresh_y[fpgm_pkg::MAX_POINTS];
	int stored_n, fresh_n;
	longint pair_dx[fpgm_pkg::MAX_POINTS], pair_dy[fpgm_pkg::MAX_POINTS];
	longint pair_wt[fpgm_pkg::MAX_POINTS];
	longint smooth_h, smooth_v;

	// Test bookkeeping.
	int mismatches, beats_checked, updates_seen, items_sent, frames_sent;
	bit link_busy;
	int burst_left;
	int scene_x[SCENE_MAX], scene_y[SCENE_MAX];

	// Rounds to nearest with ties away from zero; den is always positive.
	function automatic longint round_div(longint num, longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic longint floor_sqrt(longint v);
		longint unsigned rem, root, bitv;
		rem = v;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > rem)
			bitv >>= 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(root);
	endfunction

	function automatic longint clamp_offset(longint v);
		if (v > 64'sd8388607)
			return 64'sd8388607;
		if (v < -64'sd8388608)
			return -64'sd8388608;
		return v;
	endfunction

	// Pairs each reference point with its nearest fresh point, earliest on a tie, and
	// keeps the shift when the distance is strictly inside the match radius.
	function automatic int pair_with_fresh(bit self_match);
		longint r2, d2, best, dx, dy, rx, ry;
		int pairs, ref_n, pick;
		bit found;
		r2 = longint'(radius_q) * radius_q;
		pairs = 0;
		ref_n = self_match ? fresh_n : stored_n;
		for (int i = 0; i < ref_n; i++) begin
			rx = self_match ? fresh_x[i] : stored_x[i];
			ry = self_match ? fresh_y[i] : stored_y[i];
			found = 0;
			best = 0;
			pick = 0;
			for (int j = 0; j < fresh_n; j++) begin
				dx = longint'(fresh_x[j]) - rx;
				dy = longint'(fresh_y[j]) - ry;
				d2 = dx * dx + dy * dy;
				if (!found || d2 < best) begin
					found = 1;
					best = d2;
					pick = j;
				end
			end
			if (found && best < r2) begin
				pair_dx[pairs] = longint'(fresh_x[pick]) - rx;
				pair_dy[pairs] = longint'(fresh_y[pick]) - ry;
				pairs++;
			end
		end
		return pairs;
	endfunction

	// Weighted mean of the shifts in 1/16 pixel.
	function automatic void weighted_shift(int pairs, output longint mx, output longint my);
		longint sx, sy, sw;
		sx = 0;
		sy = 0;
		sw = 0;
		for (int i = 0; i < pairs; i++) begin
			sx += pair_wt[i] * pair_dx[i] * 16;
			sy += pair_wt[i] * pair_dy[i] * 16;
			sw += pair_wt[i];
		end
		if (sw <= 0)
			sw = 1;
		mx = round_div(sx, sw);
		my = round_div(sy, sw);
	endfunction

	// Iteratively reweighted mean; the returned mean is the one formed at the start of
	// the last round, before that round's weight update.
	function automatic void robust_shift(int pairs, output longint mx, output longint my);
		longint nw[fpgm_pkg::MAX_POINTS];
		longint wmax, dx, dy, spread;
		for (int i = 0; i < pairs; i++)
			pair_wt[i] = fpgm_pkg::WEIGHT_ONE;
		weighted_shift(pairs, mx, my);
		for (int r = 0; r < int'(rounds_q); r++) begin
			wmax = 0;
			weighted_shift(pairs, mx, my);
			for (int i = 0; i < pairs; i++) begin
				dx = mx - pair_dx[i] * 16;
				dy = my - pair_dy[i] * 16;
				spread = floor_sqrt(dx * dx + dy * dy);
				nw[i] = (pair_wt[i] << 24) / (256 + spread);
				if (nw[i] > wmax)
					wmax = nw[i];
			end
			if (wmax == 0)
				wmax = 1;
			for (int i = 0; i < pairs; i++)
				pair_wt[i] = nw[i] * fpgm_pkg::WEIGHT_ONE / wmax;
		end
	endfunction

	// Folds one accepted point beat into the predictor; a closing beat yields one
	// expected motion beat and rotates the point stores.
	function automatic void absorb_point(logic [fpgm_pkg::COORD_W-1:0] x,
			logic [fpgm_pkg::COORD_W-1:0] y, logic present, logic last);
		motion_beat_t beat;
		int pairs, need;
		longint mx, my;
		if (present && fresh_n < fpgm_pkg::MAX_POINTS) begin
			fresh_x[fresh_n] = x;
			fresh_y[fresh_n] = y;
			fresh_n++;
		end
		if (!last)
			return;
		pairs = pair_with_fresh(stored_n == 0);
		need = (min_pairs_q == 0) ? 1 : int'(min_pairs_q);
		beat.updated = 1'b0;
		if (pairs >= need) begin
			robust_shift(pairs, mx, my);
			smooth_h = clamp_offset(round_div(longint'(keep_q) * smooth_h
				+ longint'(gain_q) * mx, 32768));
			smooth_v = clamp_offset(round_div(longint'(keep_q) * smooth_v
				+ longint'(gain_q) * my, 32768));
			beat.updated = 1'b1;
		end
		beat.horiz = smooth_h[fpgm_pkg::OFS_W-1:0];
		beat.vert = smooth_v[fpgm_pkg::OFS_W-1:0];
		beat.matched = pairs[fpgm_pkg::PT_CNT_W-1:0];
		pending_motion = {pending_motion, beat};
		for (int i = 0; i < fpgm_pkg::MAX_POINTS; i++) begin
			stored_x[i] = fresh_x[i];
			stored_y[i] = fresh_y[i];
		end
		stored_n = fresh_n;
		fresh_n = 0;
	endfunction

	// Motion channel: the ready pattern changes character in turn, from no
	// stalls at all to mostly stalled, and every beat is compared with the oldest
	// expectation.
	int unsigned rx_cycle;
	always @(posedge clk) begin
		motion_beat_t want;
		rx_cycle <= rx_cycle + 1;
		case ((rx_cycle >> 7) % 4)
			0: motion.ready <= 1'b1;
			1: motion.ready <= ($urandom % 4) != 0;
			2: motion.ready <= (rx_cycle % 16) < 3;
			default: motion.ready <= rx_cycle[0];
		endcase
		if (arst_n && motion.valid === 1'b1 && motion.ready === 1'b1) begin
			beats_checked++;
			if (pending_motion.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: motion beat with nothing expected", $realtime);
			end else begin
				want = pending_motion.pop_front();
				if (motion.estimate_updated === 1'b1)
					updates_seen++;
				if (motion.horiz_offset !== want.horiz || motion.vert_offset !== want.vert
						|| motion.estimate_updated !== want.updated
						|| motion.matched_count !== want.matched) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: exp h=%0d v=%0d u=%0b n=%0d got h=%0d v=%0d u=%0b n=%0d",
							$realtime, want.horiz, want.vert, want.updated, want.matched,
							motion.horiz_offset, motion.vert_offset,
							motion.estimate_updated, motion.matched_count);
				end
			end
		end
	end

	// Sends one point beat and waits for it to be taken. The sender runs in bursts;
	// at the end of a burst valid drops for a random gap.
	task automatic push_point(logic [fpgm_pkg::COORD_W-1:0] x,
			logic [fpgm_pkg::COORD_W-1:0] y, logic present, logic last);
		points.valid <= 1'b1;
		points.point_x <= x;
		points.point_y <= y;
		points.point_present <= present;
		points.frame_last <= last;
		link_busy = 1;
		do
			@(posedge clk);
		while (points.ready !== 1'b1);
		absorb_point(x, y, present, last);
		items_sent++;
		if (last)
			frames_sent++;
		burst_left--;
		if (burst_left <= 0) begin
			points.valid <= 1'b0;
			link_busy = 0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
			burst_left = ($urandom % 4 == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
		end
	endtask

	// Holds the sender until every expected beat is back, then lets the core settle.
	task automatic drain_motion();
		if (link_busy) begin
			points.valid <= 1'b0;
			link_busy = 0;
		end
		while (pending_motion.size() != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);
	endtask

	// APB write: setup, then access; the register takes the value at the edge where
	// psel, penable, pwrite and pready are all high.
	task automatic reg_write(logic [2:0] idx, int unsigned value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			fpgm_pkg::REG_MATCH_RADIUS:  radius_q = value & 32'hFFF;
			fpgm_pkg::REG_KEEP_FACTOR:   keep_q = value & 32'h7FFF;
			fpgm_pkg::REG_NEW_FACTOR:    gain_q = value & 32'h7FFF;
			fpgm_pkg::REG_REFINE_ROUNDS: rounds_q = value & 32'h3F;
			fpgm_pkg::REG_MIN_MATCHES:   min_pairs_q = value & 32'h7F;
			default: ;
		endcase
	endtask

	task automatic load_config(int unsigned radius, int unsigned keep, int unsigned gain,
			int unsigned rounds, int unsigned min_pairs);
		drain_motion();
		reg_write(fpgm_pkg::REG_MATCH_RADIUS, radius);
		reg_write(fpgm_pkg::REG_KEEP_FACTOR, keep);
		reg_write(fpgm_pkg::REG_NEW_FACTOR, gain);
		reg_write(fpgm_pkg::REG_REFINE_ROUNDS, rounds);
		reg_write(fpgm_pkg::REG_MIN_MATCHES, min_pairs);
	endtask

	task automatic new_scene(int count);
		for (int i = 0; i < count; i++) begin
			scene_x[i] = $urandom_range(0, 65535);
			scene_y[i] = $urandom_range(0, 65535);
		end
	endtask

	// Sends one frame of the tracked scene moved by one global shift plus small jitter.
	// With noise, outliers and empty markers are mixed in, and the frame may close on
	// an empty marker.
	task automatic stream_frame(int count, int shift_x, int shift_y, bit noisy);
		int jx, jy;
		bit marker_close;
		marker_close = noisy && ($urandom % 4 == 0);
		for (int i = 0; i < count; i++) begin
			scene_x[i] = (scene_x[i] + shift_x) & 16'hFFFF;
			scene_y[i] = (scene_y[i] + shift_y) & 16'hFFFF;
			jx = noisy ? $urandom_range(0, 6) - 3 : 0;
			jy = noisy ? $urandom_range(0, 6) - 3 : 0;
			if (noisy && $urandom % 6 == 0)
				push_point(16'($urandom), 16'($urandom), 1'b1, 1'b0);
			if (noisy && $urandom % 8 == 0)
				push_point(16'($urandom), 16'($urandom), 1'b0, 1'b0);
			push_point(16'((scene_x[i] + jx) & 16'hFFFF), 16'((scene_y[i] + jy) & 16'hFFFF),
				1'b1, (i == count - 1) && !marker_close);
		end
		if (marker_close || count == 0)
			push_point(16'($urandom), 16'($urandom), 1'b0, 1'b1);
	endtask

	// Reset values: first frame matched against itself, a moving frame, an empty frame
	// that drops every stored point, then a frame that again matches itself.
	task automatic test_reset_defaults();
		new_scene(5);
		stream_frame(5, 0, 0, 0);
		stream_frame(5, 40, -24, 0);
		stream_frame(0, 0, 0, 0);
		stream_frame(5, 8, 8, 0);
	endtask

	// Coordinate extremes, a tie between two equally distant fresh points, and the
	// widest register values with the plain mean.
	task automatic test_extremes();
		load_config(4095, 32767, 32767, 0, 1);
		push_point(16'h0000, 16'h0000, 1'b1, 1'b0);
		push_point(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
		push_point(16'h0010, 16'h0000, 1'b1, 1'b0);
		push_point(16'hFFEF, 16'hFFFF, 1'b1, 1'b1);
		// The stored point at 0x0000,0x0040 lies as far from both fresh points, so the earlier one wins.
		push_point(16'h0040, 16'h0000, 1'b1, 1'b0);
		push_point(16'h0000, 16'h0040, 1'b1, 1'b1);
		push_point(16'h0020, 16'h0020, 1'b1, 1'b0);
		push_point(16'h0020, 16'h0060, 1'b1, 1'b1);
		// A zero radius pairs nothing and a zero minimum behaves as one.
		load_config(0, 0, 0, 1, 0);
		push_point(16'h1234, 16'h4321, 1'b1, 1'b1);
		load_config(100, 16384, 16384, 2, 0);
		push_point(16'h1240, 16'h4300, 1'b1, 1'b1);
		drain_motion();
		reg_write(UNMAPPED_REG, 32'hFFFF_FFFF);
		push_point(16'h1250, 16'h4310, 1'b1, 1'b1);
	endtask

	// A frame of more points than the store holds, then a minimum of the full store.
	task automatic test_point_overflow();
		load_config(300, 20000, 12000, 1, 64);
		stream_frame(0, 0, 0, 0);
		new_scene(SCENE_MAX);
		stream_frame(70, 0, 0, 0);
		stream_frame(70, 16, -16, 0);
	endtask

	// The most reweighting rounds on a few small noisy frames, where outliers may be mixed in.
	task automatic test_long_refine();
		load_config(800, 30000, 2700, 63, 2);
		new_scene(4);
		for (int f = 0; f < 3; f++)
			stream_frame(4, $urandom_range(0, 120) - 60, $urandom_range(0, 120) - 60, 1);
	endtask

	// Random phases: each phase draws its own settings and mostly sends a tracked
	// scene with random motion; some frames restart the scene or are pure noise.
	task automatic test_random_tracking();
		int quota, cnt, reach;
		for (int phase = 0; phase < 6; phase++) begin
			load_config($urandom_range(96, 4095), $urandom_range(0, 32767),
				$urandom_range(0, 32767), $urandom_range(0, 4), $urandom_range(1, 6));
			new_scene(8);
			quota = items_sent + 105;
			while (items_sent < quota) begin
				cnt = ($urandom % 10 == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
				reach = int'(radius_q) / 3 + 1;
				if ($urandom % 10 == 0)
					new_scene(cnt);
				if ($urandom % 12 == 0) begin
					repeat ($urandom_range(1, 4))
						push_point(16'($urandom), 16'($urandom), 1'(($urandom)), 1'b0);
					push_point(16'($urandom), 16'($urandom), 1'(($urandom)), 1'b1);
				end else begin
					stream_frame(cnt, $urandom_range(0, 2 * reach) - reach,
						$urandom_range(0, 2 * reach) - reach, 1);
				end
			end
			// The sender holds here once until the core has answered everything.
			if (phase == 2)
				drain_motion();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		points.valid <= 1'b0;
		points.point_x <= '0;
		points.point_y <= '0;
		points.point_present <= 1'b0;
		points.frame_last <= 1'b0;
		rx_cycle = 0;
		radius_q = fpgm_pkg::RST_MATCH_RADIUS;
		keep_q = fpgm_pkg::RST_KEEP_FACTOR;
		gain_q = fpgm_pkg::RST_NEW_FACTOR;
		rounds_q = fpgm_pkg::RST_REFINE_ROUNDS;
		min_pairs_q = fpgm_pkg::RST_MIN_MATCHES;
		stored_n = 0;
		fresh_n = 0;
		smooth_h = 0;
		smooth_v = 0;
		burst_left = 4;
		link_busy = 0;
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_extremes();
		test_point_overflow();
		test_long_refine();
		test_random_tracking();

		drain_motion();
		repeat (50)
			@(posedge clk);
		$display("Sent %0d point beats in %0d frames under several register settings.",
			items_sent, frames_sent);
		$display("Checked %0d motion beats, %0d with updated offsets, %0d mismatches.",
			beats_checked, updates_seen, mismatches);
		if (mismatches == 0 && pending_motion.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Watchdog well beyond the slowest legal run.
	initial begin
		#60000000;
		$display("Timed out with %0d motion beats outstanding.", pending_motion.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
